// ----- hdl/hhac_pkg.sv -----
// shared types and constants for the handle heap allocator and compactor
`timescale 1ns / 1ps
package hhac_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int MAX_MOVES    = 63;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REPLACE = 2'd2,
    OP_PACK    = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_HANDLE = 3'd1;
  localparam logic [2:0] ST_HEAP_FULL = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_REC_FULL = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic alloc_do;
    logic free_do;
    logic ho_latch;
    logic rec_rd;
    logic i_inc;
    logic set_match;
    logic repl_do;
    logic ho_rd_rec;
    logic pk_keep;
    logic pk_fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic repl_ok;
    logic scan_end;
    logic rec_match;
    logic pk_live;
    logic pk_move;
  } stat_t;

endpackage

// ----- hdl/handle_heap_allocator_compactor_core.sv -----
// top level of the handle heap allocator and compactor
`timescale 1ns / 1ps
// usage
//   in_* channel: one request per operation (allocate, free, replace, pack),
//   taken when in_valid is high and in_stall low; in_stall is high while a
//   request is being worked on, so requests are handled one at a time
//   out_* channel: result requests held in an output register, taken when
//   out_valid is high and out_stall low; out_last marks the final result
//   cfg_wr_en writes heap_base; only while no request is in flight
// timing
//   allocate and free: result loaded in the state after acceptance, once out_free
//   replace: a handle check, then per block record before the match a record read
//     and a compare (record store read port), then the result
//   pack: per block record a record read, then a handle table read, then a check,
//     and after that the end of the scan and the final count
//   the next request is taken the cycle after the last result is loaded
// reset
//   synchronous active low; clears heap_base, handle validity, queue, allocation
//   counters and out_valid; the ram contents are left as they are and never used unwritten
// stall
//   while out_stall holds a result, the walk waits at the next result it
//   wants to load; no result is ever lost or duplicated
module handle_heap_allocator_compactor_core import hhac_pkg::*; #(
  parameter int MAX_HANDLES = 64,
  parameter int HEAP_BYTES  = 65536,
  parameter int MAX_BLOCKS  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_data_size,
  input  logic [7:0]  in_object_kind,
  input  logic [5:0]  in_handle,
  input  logic [5:0]  in_target_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_result_handle,
  output logic [31:0] out_block_address,
  output logic [31:0] out_move_source,
  output logic [31:0] out_move_dest,
  output logic [16:0] out_move_length,
  output logic [6:0]  out_live_count,
  output logic        out_last
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  hhac_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_operation(in_operation),
    .stat(stat), .cmd(cmd), .in_stall(in_stall)
  );

  // tables, queue, records and result register
  hhac_datapath #(
    .MAX_HANDLES(MAX_HANDLES), .HEAP_BYTES(HEAP_BYTES), .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_data_size(in_data_size),
    .in_object_kind(in_object_kind), .in_handle(in_handle),
    .in_target_handle(in_target_handle),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_result_handle(out_result_handle), .out_block_address(out_block_address),
    .out_move_source(out_move_source), .out_move_dest(out_move_dest),
    .out_move_length(out_move_length), .out_live_count(out_live_count),
    .out_last(out_last)
  );

endmodule

// ----- hdl/hhac_ram.sv -----
// generic single write port, single registered read port ram
`timescale 1ns / 1ps
module hhac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/hhac_ctrl.sv -----
// sequencing state machine for the handle heap allocator
`timescale 1ns / 1ps
module hhac_ctrl import hhac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       in_stall
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ALLOC = 11'b00000000010,
    S_FREE  = 11'b00000000100,
    S_RCHK  = 11'b00000001000,
    S_RRD   = 11'b00000010000,
    S_RCMP  = 11'b00000100000,
    S_REMIT = 11'b00001000000,
    S_PRD   = 11'b00010000000,
    S_PHO   = 11'b00100000000,
    S_PCHK  = 11'b01000000000,
    S_PFIN  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (op_t'(in_operation))
            OP_ALLOC:   state_nxt = S_ALLOC;
            OP_FREE:    state_nxt = S_FREE;
            OP_REPLACE: state_nxt = S_RCHK;
            OP_PACK:    state_nxt = S_PRD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (stat.out_free) begin
          cmd.alloc_do = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FREE: begin
        if (stat.out_free) begin
          cmd.free_do = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_RCHK: begin
        cmd.ho_latch = 1'b1;
        state_nxt    = stat.repl_ok ? S_RRD : S_REMIT;
      end
      S_RRD: begin
        if (stat.scan_end) begin
          state_nxt = S_REMIT;
        end else begin
          cmd.rec_rd = 1'b1;
          state_nxt  = S_RCMP;
        end
      end
      S_RCMP: begin
        if (stat.rec_match) begin
          cmd.set_match = 1'b1;
          state_nxt     = S_REMIT;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_RRD;
        end
      end
      S_REMIT: begin
        if (stat.out_free) begin
          cmd.repl_do = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_PRD: begin
        if (stat.scan_end) begin
          state_nxt = S_PFIN;
        end else begin
          cmd.rec_rd = 1'b1;
          state_nxt  = S_PHO;
        end
      end
      S_PHO: begin
        cmd.ho_rd_rec = 1'b1;
        state_nxt     = S_PCHK;
      end
      S_PCHK: begin
        if (!stat.pk_live) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_PRD;
        end else if (!stat.pk_move || stat.out_free) begin
          cmd.pk_keep = 1'b1;
          cmd.i_inc   = 1'b1;
          state_nxt   = S_PRD;
        end
      end
      S_PFIN: begin
        if (stat.out_free) begin
          cmd.pk_fin = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/hhac_datapath.sv -----
// handle tables, freed handle queue, block records and result register
`timescale 1ns / 1ps
module hhac_datapath import hhac_pkg::*; #(
  parameter int MAX_HANDLES = 64,
  parameter int HEAP_BYTES  = 65536,
  parameter int MAX_BLOCKS  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic [15:0] in_data_size,
  input  logic [7:0]  in_object_kind,
  input  logic [5:0]  in_handle,
  input  logic [5:0]  in_target_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_result_handle,
  output logic [31:0] out_block_address,
  output logic [31:0] out_move_source,
  output logic [31:0] out_move_dest,
  output logic [16:0] out_move_length,
  output logic [6:0]  out_live_count,
  output logic        out_last
);

  localparam int HIW  = $clog2(MAX_HANDLES);
  localparam int OW   = $clog2(HEAP_BYTES);
  localparam int BW   = $clog2(MAX_BLOCKS);
  localparam int RCW  = $clog2(MAX_BLOCKS + 1);
  localparam int RECW = 2 * OW + 14;

  // request fields
  logic [15:0] size_r;
  logic [7:0]  kind_r;
  logic [5:0]  h_r, t_r;

  // persistent state
  logic [31:0]            heap_base_r;
  logic [MAX_HANDLES-1:0] valid_r;
  logic [6:0]             nfresh_r;
  logic [6:0]             fcnt_r;
  logic [HIW-1:0]         head_r, tail_r;
  logic [16:0]            alloc_r;
  logic [6:0]             obj_r;
  logic [RCW-1:0]         rec_cnt_r;

  // walk state
  logic [RCW-1:0] i_r, kept_r;
  logic [16:0]    dest_r;
  logic [6:0]     live_r;
  logic [5:0]     k_r;
  logic           match_r;
  logic [OW-1:0]  ho_h_r;

  // result register
  logic        ov_r;
  logic [2:0]  o_status_r;
  logic [5:0]  o_handle_r;
  logic [31:0] o_addr_r, o_src_r, o_dst_r;
  logic [16:0] o_len_r;
  logic [6:0]  o_cnt_r;
  logic        o_last_r;

  // ram ports
  logic           ho_we, ho_re;
  logic [HIW-1:0] ho_wa, ho_ra;
  logic [OW-1:0]  ho_wd, ho_rd;
  logic           ff_we;
  logic [5:0]     ff_rd;
  logic           rec_we;
  logic [BW-1:0]  rec_wa;
  logic [RECW-1:0] rec_wd, rec_rd;

  hhac_ram #(.WIDTH(OW), .DEPTH(MAX_HANDLES)) u_ho (
    .clk(clk), .wr_en(ho_we), .wr_addr(ho_wa), .wr_data(ho_wd),
    .rd_en(ho_re), .rd_addr(ho_ra), .rd_data(ho_rd)
  );

  hhac_ram #(.WIDTH(6), .DEPTH(MAX_HANDLES)) u_fifo (
    .clk(clk), .wr_en(ff_we), .wr_addr(tail_r), .wr_data(h_r),
    .rd_en(cmd.accept), .rd_addr(head_r), .rd_data(ff_rd)
  );

  hhac_ram #(.WIDTH(RECW), .DEPTH(MAX_BLOCKS)) u_rec (
    .clk(clk), .wr_en(rec_we), .wr_addr(rec_wa), .wr_data(rec_wd),
    .rd_en(cmd.rec_rd), .rd_addr(i_r[BW-1:0]), .rd_data(rec_rd)
  );

  // record fields: offset, size, handle, kind
  logic [OW-1:0] rec_off, rec_sz;
  logic [5:0]    rec_h;
  logic [7:0]    rec_kind;
  assign rec_off  = rec_rd[RECW-1 -: OW];
  assign rec_sz   = rec_rd[RECW-OW-1 -: OW];
  assign rec_h    = rec_rd[13:8];
  assign rec_kind = rec_rd[7:0];

  // checks
  logic h_map, t_map, repl_ok, rh_map;
  logic from_fifo, no_h, heap_full, rec_full, alloc_ok;
  logic [17:0] need;
  logic [5:0]  nh;
  logic [16:0] pk_len;
  logic        pk_live, pk_move, out_free;
  logic [6:0]  obj_dec;

  assign h_map   = ({1'b0, h_r} < 7'(MAX_HANDLES)) && valid_r[h_r[HIW-1:0]];
  assign t_map   = ({1'b0, t_r} < 7'(MAX_HANDLES)) && valid_r[t_r[HIW-1:0]];
  assign repl_ok = h_map && t_map && (h_r != t_r);

  assign from_fifo = (fcnt_r != 7'd0);
  assign no_h      = !from_fifo && (nfresh_r >= 7'(MAX_HANDLES));
  assign need      = {1'b0, alloc_r} + 18'(HEADER_BYTES) + 18'(size_r);
  assign heap_full = need > 18'(HEAP_BYTES);
  assign rec_full  = rec_cnt_r >= RCW'(MAX_BLOCKS);
  assign alloc_ok  = !no_h && !heap_full && !rec_full;
  assign nh        = from_fifo ? ff_rd : nfresh_r[5:0];

  assign rh_map  = ({1'b0, rec_h} < 7'(MAX_HANDLES)) && valid_r[rec_h[HIW-1:0]];
  assign pk_live = rh_map && (ho_rd == rec_off);
  assign pk_len  = 17'(rec_sz) + 17'(HEADER_BYTES);
  assign pk_move = pk_live && (dest_r != 17'(rec_off)) && (k_r != 6'(MAX_MOVES));
  assign out_free = !ov_r || !out_stall;
  assign obj_dec  = (obj_r != 7'd0) ? obj_r - 7'd1 : obj_r;

  assign stat.out_free  = out_free;
  assign stat.repl_ok   = repl_ok;
  assign stat.scan_end  = (i_r == rec_cnt_r);
  assign stat.rec_match = (rec_off == ho_h_r);
  assign stat.pk_live   = pk_live;
  assign stat.pk_move   = pk_move;

  logic unmap;
  assign unmap = (cmd.free_do && h_map) || (cmd.repl_do && repl_ok);
  assign ff_we = unmap && (fcnt_r < 7'(MAX_HANDLES));

  // ram address and data selection
  always_comb begin
    ho_we  = 1'b0;
    ho_wa  = nh[HIW-1:0];
    ho_wd  = alloc_r[OW-1:0];
    rec_we = 1'b0;
    rec_wa = rec_cnt_r[BW-1:0];
    rec_wd = {alloc_r[OW-1:0], size_r[OW-1:0], nh, kind_r};
    if (cmd.alloc_do && alloc_ok) begin
      ho_we  = 1'b1;
      rec_we = 1'b1;
    end else if (cmd.repl_do && repl_ok) begin
      ho_we  = 1'b1;
      ho_wa  = t_r[HIW-1:0];
      ho_wd  = ho_h_r;
      rec_we = match_r;
      rec_wa = i_r[BW-1:0];
      rec_wd = {rec_off, rec_sz, t_r, rec_kind};
    end else if (cmd.pk_keep) begin
      ho_we  = 1'b1;
      ho_wa  = rec_h[HIW-1:0];
      ho_wd  = dest_r[OW-1:0];
      rec_we = 1'b1;
      rec_wa = kept_r[BW-1:0];
      rec_wd = {dest_r[OW-1:0], rec_sz, rec_h, rec_kind};
    end
    ho_re = cmd.accept || cmd.ho_rd_rec;
    ho_ra = cmd.ho_rd_rec ? rec_h[HIW-1:0] : in_handle[HIW-1:0];
  end

  // result selection
  logic        emit;
  logic [2:0]  e_status;
  logic [5:0]  e_handle;
  logic [31:0] e_addr, e_src, e_dst;
  logic [16:0] e_len;
  logic [6:0]  e_cnt;
  logic        e_last;

  always_comb begin
    emit     = cmd.alloc_do || cmd.free_do || cmd.repl_do || cmd.pk_fin ||
               (cmd.pk_keep && pk_move);
    e_status = ST_OK;
    e_handle = '0;
    e_addr   = '0;
    e_src    = '0;
    e_dst    = '0;
    e_len    = '0;
    e_cnt    = obj_r;
    e_last   = 1'b1;
    if (cmd.alloc_do) begin
      if (no_h) begin
        e_status = ST_NO_HANDLE;
      end else if (heap_full) begin
        e_status = ST_HEAP_FULL;
      end else if (rec_full) begin
        e_status = ST_REC_FULL;
      end else begin
        e_handle = nh;
        e_addr   = heap_base_r + 32'(alloc_r);
        e_cnt    = obj_r + 7'd1;
      end
    end else if (cmd.free_do) begin
      if (h_map) begin
        e_cnt = obj_dec;
      end else begin
        e_status = ST_IGNORED;
      end
    end else if (cmd.repl_do) begin
      if (repl_ok) begin
        e_cnt = obj_dec;
      end else begin
        e_status = ST_IGNORED;
      end
    end else if (cmd.pk_keep) begin
      e_src  = heap_base_r + 32'(rec_off);
      e_dst  = heap_base_r + 32'(dest_r);
      e_len  = pk_len;
      e_cnt  = live_r + 7'd1;
      e_last = 1'b0;
    end else begin
      e_cnt = live_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
      valid_r     <= '0;
      nfresh_r    <= 7'd1;
      fcnt_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      alloc_r     <= '0;
      obj_r       <= '0;
      rec_cnt_r   <= '0;
      ov_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        heap_base_r <= cfg_wr_data;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      if (cmd.alloc_do && alloc_ok) begin
        valid_r[nh[HIW-1:0]] <= 1'b1;
        if (from_fifo) begin
          fcnt_r <= fcnt_r - 7'd1;
          head_r <= (head_r == HIW'(MAX_HANDLES - 1)) ? '0 : head_r + 1'b1;
        end else begin
          nfresh_r <= nfresh_r + 7'd1;
        end
        rec_cnt_r <= rec_cnt_r + 1'b1;
        obj_r     <= obj_r + 7'd1;
        alloc_r   <= need[16:0];
      end
      if (unmap) begin
        valid_r[h_r[HIW-1:0]] <= 1'b0;
        obj_r <= obj_dec;
        if (ff_we) begin
          fcnt_r <= fcnt_r + 7'd1;
          tail_r <= (tail_r == HIW'(MAX_HANDLES - 1)) ? '0 : tail_r + 1'b1;
        end
      end
      if (cmd.pk_fin) begin
        rec_cnt_r <= kept_r;
        alloc_r   <= dest_r;
        obj_r     <= live_r;
      end
    end
  end

  // request, walk and result payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      size_r  <= in_data_size;
      kind_r  <= in_object_kind;
      h_r     <= in_handle;
      t_r     <= in_target_handle;
      i_r     <= '0;
      kept_r  <= '0;
      dest_r  <= '0;
      live_r  <= '0;
      k_r     <= '0;
      match_r <= 1'b0;
    end
    if (cmd.ho_latch) begin
      ho_h_r <= ho_rd;
    end
    if (cmd.i_inc) begin
      i_r <= i_r + 1'b1;
    end
    if (cmd.set_match) begin
      match_r <= 1'b1;
    end
    if (cmd.pk_keep) begin
      kept_r <= kept_r + 1'b1;
      dest_r <= dest_r + pk_len;
      live_r <= live_r + 7'd1;
      if (pk_move) begin
        k_r <= k_r + 6'd1;
      end
    end
    if (emit) begin
      o_status_r <= e_status;
      o_handle_r <= e_handle;
      o_addr_r   <= e_addr;
      o_src_r    <= e_src;
      o_dst_r    <= e_dst;
      o_len_r    <= e_len;
      o_cnt_r    <= e_cnt;
      o_last_r   <= e_last;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = o_status_r;
  assign out_result_handle = o_handle_r;
  assign out_block_address = o_addr_r;
  assign out_move_source   = o_src_r;
  assign out_move_dest     = o_dst_r;
  assign out_move_length   = o_len_r;
  assign out_live_count    = o_cnt_r;
  assign out_last          = o_last_r;

endmodule

// ----- verif/handle_heap_allocator_compactor_core_tb.sv -----
// testbench for the handle heap allocator and compactor core
`timescale 1ns / 1ps
module handle_heap_allocator_compactor_core_tb;
  import hhac_pkg::*;

  // block sizes as built here
  localparam int NUM_HANDLES = 64;
  localparam int HEAP_SIZE   = 65536;
  localparam int NUM_RECORDS = 256;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [15:0] in_data_size;
  logic [7:0]  in_object_kind;
  logic [5:0]  in_handle;
  logic [5:0]  in_target_handle;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [5:0]  out_result_handle;
  logic [31:0] out_block_address;
  logic [31:0] out_move_source;
  logic [31:0] out_move_dest;
  logic [16:0] out_move_length;
  logic [6:0]  out_live_count;
  logic        out_last;

  handle_heap_allocator_compactor_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_data_size      (in_data_size),
    .in_object_kind    (in_object_kind),
    .in_handle         (in_handle),
    .in_target_handle  (in_target_handle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_result_handle (out_result_handle),
    .out_block_address (out_block_address),
    .out_move_source   (out_move_source),
    .out_move_dest     (out_move_dest),
    .out_move_length   (out_move_length),
    .out_live_count    (out_live_count),
    .out_last          (out_last)
  );

  // one expected result of the block
  typedef struct {
    logic [2:0]  status;
    logic [5:0]  handle;
    logic [31:0] address;
    logic [31:0] source;
    logic [31:0] dest;
    logic [16:0] length;
    logic [6:0]  live;
    logic        last;
  } heap_result_t;

  heap_result_t pending_results[$];

  // shadow of the allocator state
  logic [31:0] shadow_base;
  int          slot_offset[NUM_HANDLES];
  bit          slot_mapped[NUM_HANDLES];
  int          fresh_handle;
  int          recycled_handles[$];
  int          bump_offset;
  int          live_objects;
  int          blk_offset[NUM_RECORDS];
  int          blk_size[NUM_RECORDS];
  int          blk_handle[NUM_RECORDS];
  int          blk_count;
  int          granted_handle;

  // run bookkeeping
  int cycle_count;
  int error_count;
  int results_seen;
  int moves_seen;
  int requests_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  bit hold_start;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall guard against a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what,
             got, want);
  endtask

  // result side: checks every taken result and drives the stall pattern
  always @(posedge clk) begin
    heap_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_status), 32'd0);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status)
          report_mismatch("status", 32'(out_status), 32'(exp_res.status));
        if (out_result_handle !== exp_res.handle)
          report_mismatch("result_handle", 32'(out_result_handle), 32'(exp_res.handle));
        if (out_block_address !== exp_res.address)
          report_mismatch("block_address", out_block_address, exp_res.address);
        if (out_move_source !== exp_res.source)
          report_mismatch("move_source", out_move_source, exp_res.source);
        if (out_move_dest !== exp_res.dest)
          report_mismatch("move_dest", out_move_dest, exp_res.dest);
        if (out_move_length !== exp_res.length)
          report_mismatch("move_length", 32'(out_move_length), 32'(exp_res.length));
        if (out_live_count !== exp_res.live)
          report_mismatch("live_count", 32'(out_live_count), 32'(exp_res.live));
        if (out_last !== exp_res.last)
          report_mismatch("last", 32'(out_last), 32'(exp_res.last));
        if (!exp_res.last) moves_seen++;
      end
    end
    // long hold-off, counted here, so the block backs up into its input
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  function automatic void push_result(logic [2:0] st, int h, logic [31:0] addr,
                                      logic [31:0] src, logic [31:0] dst, int len,
                                      int live, logic last);
    heap_result_t r;
    r.status  = st;
    r.handle  = h[5:0];
    r.address = addr;
    r.source  = src;
    r.dest    = dst;
    r.length  = len[16:0];
    r.live    = live[6:0];
    r.last    = last;
    pending_results.push_back(r);
  endfunction

  function automatic bit is_mapped(int h);
    return h != 0 && h < fresh_handle && slot_mapped[h];
  endfunction

  function automatic void release_handle(int h);
    if (recycled_handles.size() < NUM_HANDLES) recycled_handles.push_back(h);
    slot_mapped[h] = 1'b0;
    if (live_objects > 0) live_objects--;
  endfunction

  // expected results of one request, updating the shadow state
  function automatic void predict_heap_op(op_t op, int size, int h, int t);
    int nh;
    int dest;
    int kept;
    int live;
    int moves;
    int len;
    int rh;
    granted_handle = 0;
    case (op)
      OP_ALLOC: begin
        if (recycled_handles.size() == 0 && fresh_handle >= NUM_HANDLES)
          push_result(ST_NO_HANDLE, 0, 0, 0, 0, 0, live_objects, 1'b1);
        else if (bump_offset + HEADER_BYTES + size > HEAP_SIZE)
          push_result(ST_HEAP_FULL, 0, 0, 0, 0, 0, live_objects, 1'b1);
        else if (blk_count >= NUM_RECORDS)
          push_result(ST_REC_FULL, 0, 0, 0, 0, 0, live_objects, 1'b1);
        else begin
          if (recycled_handles.size() > 0) nh = recycled_handles.pop_front();
          else nh = fresh_handle++;
          slot_offset[nh] = bump_offset;
          slot_mapped[nh] = 1'b1;
          blk_offset[blk_count] = bump_offset;
          blk_size[blk_count]   = size;
          blk_handle[blk_count] = nh;
          blk_count++;
          live_objects++;
          granted_handle = nh;
          push_result(ST_OK, nh, shadow_base + bump_offset, 0, 0, 0, live_objects, 1'b1);
          bump_offset += HEADER_BYTES + size;
        end
      end
      OP_FREE: begin
        if (!is_mapped(h)) begin
          push_result(ST_IGNORED, 0, 0, 0, 0, 0, live_objects, 1'b1);
        end else begin
          release_handle(h);
          push_result(ST_OK, 0, 0, 0, 0, 0, live_objects, 1'b1);
        end
      end
      OP_REPLACE: begin
        if (!is_mapped(h) || !is_mapped(t) || h == t) begin
          push_result(ST_IGNORED, 0, 0, 0, 0, 0, live_objects, 1'b1);
        end else begin
          // the record of the replacement block now belongs to the target
          for (int i = 0; i < blk_count; i++) begin
            if (blk_offset[i] == slot_offset[h]) begin
              blk_handle[i] = t;
              break;
            end
          end
          slot_offset[t] = slot_offset[h];
          release_handle(h);
          push_result(ST_OK, 0, 0, 0, 0, 0, live_objects, 1'b1);
        end
      end
      default: begin
        // compaction walk in address order
        dest  = 0;
        kept  = 0;
        live  = 0;
        moves = 0;
        for (int i = 0; i < blk_count; i++) begin
          rh  = blk_handle[i];
          len = HEADER_BYTES + blk_size[i];
          if (is_mapped(rh) && slot_offset[rh] == blk_offset[i]) begin
            live++;
            if (blk_offset[i] != dest && moves < MAX_MOVES) begin
              push_result(ST_OK, 0, 0, shadow_base + blk_offset[i], shadow_base + dest,
                          len, live, 1'b0);
              moves++;
            end
            slot_offset[rh]   = dest;
            blk_offset[kept]  = dest;
            blk_size[kept]    = blk_size[i];
            blk_handle[kept]  = rh;
            kept++;
            dest += len;
          end
        end
        blk_count    = kept;
        bump_offset  = dest;
        live_objects = live;
        push_result(ST_OK, 0, 0, 0, 0, 0, live, 1'b1);
      end
    endcase
  endfunction

  // offers one request and returns in the time step it is taken
  task automatic send_request(input op_t op, input int size, input int kind,
                              input int h, input int t);
    if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_data_size     <= size[15:0];
    in_object_kind   <= kind[7:0];
    in_handle        <= h[5:0];
    in_target_handle <= t[5:0];
    predict_heap_op(op, size, h, t);
    requests_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // drain every result, then let the block settle before touching the register
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_heap_base(input logic [31:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_base = value;
    @(posedge clk);
  endtask

  // handle that is mapped most of the time, otherwise anything
  function automatic int pick_handle();
    int mapped_list[$];
    for (int i = 1; i < NUM_HANDLES; i++)
      if (is_mapped(i)) mapped_list.push_back(i);
    if (mapped_list.size() == 0 || $urandom_range(0, 3) == 0) return $urandom_range(0, 63);
    return mapped_list[$urandom_range(0, mapped_list.size() - 1)];
  endfunction

  // free every mapped handle and compact, leaving an empty heap
  task automatic empty_heap();
    for (int i = 1; i < NUM_HANDLES; i++)
      if (is_mapped(i)) send_request(OP_FREE, 0, i, i, 0);
    send_request(OP_PACK, 0, 0, 0, 0);
  endtask

  // extremes of the fields and the ignored cases of free and replace
  task automatic test_basic_ops();
    int a;
    int b;
    send_request(OP_FREE, 0, 0, 5, 0);          // handle never given out
    send_request(OP_ALLOC, 0, 8'h00, 0, 0);
    a = granted_handle;
    send_request(OP_ALLOC, 16'hFFF8, 8'hFF, 63, 63); // largest block no longer fits
    send_request(OP_ALLOC, 100, 8'hA5, 0, 0);
    b = granted_handle;
    send_request(OP_ALLOC, 16, 8'h5A, 0, 0);
    send_request(OP_FREE, 0, 0, 0, 0);          // handle zero
    send_request(OP_REPLACE, 0, 0, b, b);       // same handle
    send_request(OP_REPLACE, 0, 0, 40, b);      // replacement unmapped
    send_request(OP_REPLACE, 0, 0, b, 0);       // target unmapped
    send_request(OP_REPLACE, 0, 0, b, a);       // a takes over b's block
    send_request(OP_FREE, 0, 0, b, 0);          // b already released
    send_request(OP_PACK, 0, 0, 0, 0);
    send_request(OP_PACK, 0, 0, 0, 0);          // nothing left to move
    empty_heap();
  endtask

  // a dead block at the bottom, every handle live above it, one allocate too many,
  // then a pack that moves 63 blocks
  task automatic test_handles_and_big_pack();
    int h;
    send_request(OP_ALLOC, 24, 1, 0, 0);
    h = granted_handle;
    send_request(OP_FREE, 0, 0, h, 0);
    for (int i = 0; i < NUM_HANDLES; i++) send_request(OP_ALLOC, 8, i, 0, 0);
    send_request(OP_PACK, 0, 0, 0, 0);
    empty_heap();
  endtask

  // the largest block that fits, then heap full
  task automatic test_heap_full();
    send_request(OP_ALLOC, 16'hFFF8, 8'h3C, 0, 0);  // fills the heap exactly
    send_request(OP_ALLOC, 0, 8'h3C, 0, 0);          // heap full
    empty_heap();
  endtask

  // mostly sensible traffic on mapped handles, some noise
  task automatic run_random(input int count);
    int sel;
    int size;
    for (int n = 0; n < count; n++) begin
      sel  = $urandom_range(0, 99);
      size = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 160) : $urandom_range(0, 65535);
      if (blk_count > 200 || sel >= 92)
        send_request(OP_PACK, size, $urandom_range(0, 255), $urandom_range(0, 63),
                     $urandom_range(0, 63));
      else if (sel < 45)
        send_request(OP_ALLOC, size, $urandom_range(0, 255), $urandom_range(0, 63),
                     $urandom_range(0, 63));
      else if (sel < 72)
        send_request(OP_FREE, size, $urandom_range(0, 255), pick_handle(),
                     $urandom_range(0, 63));
      else
        send_request(OP_REPLACE, size, $urandom_range(0, 255), pick_handle(), pick_handle());
    end
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  run_random(25);
    write_heap_base(32'hFFFF_FFF0);          // addresses wrap past the top
    send_idle_pct = 50; recv_stall_pct = 0;  run_random(25);
    write_heap_base($urandom());
    send_idle_pct = 0;  recv_stall_pct = 50; run_random(25);
    write_heap_base(32'hFFFF_FFFF);
    send_idle_pct = 35; recv_stall_pct = 35; run_random(25);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    wait_idle();
    hold_start = 1'b1;
    run_random(10);
    send_request(OP_PACK, 0, 0, 0, 0);
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_operation     <= OP_ALLOC;
    in_data_size     <= '0;
    in_object_kind   <= '0;
    in_handle        <= '0;
    in_target_handle <= '0;
    out_stall        <= 1'b0;
    cycle_count    = 0;
    error_count    = 0;
    results_seen   = 0;
    moves_seen     = 0;
    requests_sent  = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    hold_start     = 1'b0;
    // shadow state after reset
    shadow_base   = '0;
    fresh_handle  = 1;
    bump_offset   = 0;
    live_objects  = 0;
    blk_count     = 0;
    for (int i = 0; i < NUM_HANDLES; i++) begin
      slot_mapped[i] = 1'b0;
      slot_offset[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    write_heap_base(32'h8000_0000);
    test_handles_and_big_pack();
    write_heap_base(32'h0000_1000);
    test_heap_full();
    write_heap_base(32'h0000_0000);
    test_random_phases();
    test_backpressure();
    wait_idle();
    repeat (50) @(posedge clk);

    $display("%0d requests over all four operations, %0d results checked (%0d moves)",
             requests_sent, results_seen, moves_seen);
    $display("covered handle and heap exhaustion, a 63-move pack, wrapping bases and stalls");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/hhac_pkg.sv
hdl/hhac_ram.sv
hdl/hhac_ctrl.sv
hdl/hhac_datapath.sv
hdl/handle_heap_allocator_compactor_core.sv
verif/handle_heap_allocator_compactor_core_tb.sv
